/* design/sldf_pkg.sv */
// Package: shared types and constants for the sync/length/checksum deframer.
package sldf_pkg;

    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] SYNC_FF  = 8'hFF;
    localparam logic [BYTE_W-1:0] SYNC_55  = 8'h55;
    localparam logic [BYTE_W:0]   CHK_BASE = 9'h100;

    // One result item as it leaves the parser.
    typedef struct packed {
        logic [BYTE_W-1:0] frame_length;
        logic              checksum_ok;
        logic              is_last;
        logic [BYTE_W-1:0] out_byte;
    } result_t;

    // Handshake status between the pipeline stages and the parser.
    typedef struct packed {
        logic in_vld;   // input register holds an item
        logic out_rdy;  // output register can load this cycle
    } stage_ctl_t;

endpackage

/* design/sldf_in_reg.sv */
// Input register stage: captures one received byte and holds it until the parser consumes it.
module sldf_in_reg (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte
    input  logic                  consume,
    output logic                  in_vld,
    output logic [sldf_pkg::BYTE_W-1:0] in_byte
);
    import sldf_pkg::*;

    logic              vld_reg;
    logic              vld_next;
    logic [BYTE_W-1:0] byte_reg;

    assign s_tready = !vld_reg || consume;
    assign vld_next = s_tready ? s_tvalid : vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

    assign in_vld  = vld_reg;
    assign in_byte = byte_reg;
endmodule

/* design/sldf_parser.sv */
// Frame parser: header hunt, length capture, running sum and checksum compare.
module sldf_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sldf_pkg::stage_ctl_t        ctl,
    input  logic [sldf_pkg::BYTE_W-1:0] in_byte,
    output logic                        consume,
    output logic                        res_vld,
    output sldf_pkg::result_t           res
);
    import sldf_pkg::*;

    localparam logic [2:0] PH_HUNT     = 3'd0;
    localparam logic [2:0] PH_AFTER_FF = 3'd1;
    localparam logic [2:0] PH_LENGTH   = 3'd2;
    localparam logic [2:0] PH_PAYLOAD  = 3'd3;
    localparam logic [2:0] PH_CHECK    = 3'd4;

    logic [2:0]        phase_reg, phase_next;
    logic [BYTE_W-1:0] remaining_reg, remaining_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [BYTE_W-1:0] length_reg, length_next;
    logic [BYTE_W-1:0] rem_dec;
    logic [BYTE_W-1:0] expect_chk;
    logic              emits;

    assign rem_dec    = remaining_reg - 8'd1;
    assign expect_chk = BYTE_W'(CHK_BASE - {1'b0, sum_reg});

    always_comb begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        sum_next       = sum_reg;
        length_next    = length_reg;
        emits          = 1'b0;
        res.out_byte     = in_byte;
        res.is_last      = 1'b0;
        res.checksum_ok  = 1'b0;
        res.frame_length = length_reg;
        case (phase_reg)
            PH_AFTER_FF: begin
                // a broken header drops both bytes
                phase_next = (in_byte == SYNC_55) ? PH_LENGTH : PH_HUNT;
            end
            PH_LENGTH: begin
                if (in_byte == '0) begin
                    phase_next = PH_HUNT;
                end else begin
                    length_next    = in_byte;
                    remaining_next = in_byte;
                    sum_next       = in_byte;
                    phase_next     = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                emits          = 1'b1;
                sum_next       = sum_reg + in_byte;
                remaining_next = rem_dec;
                if (rem_dec == '0) begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK: begin
                emits           = 1'b1;
                res.is_last     = 1'b1;
                res.checksum_ok = (in_byte == expect_chk);
                phase_next      = PH_HUNT;
            end
            default: begin
                if (in_byte == SYNC_55) begin
                    phase_next = PH_LENGTH;
                end else if (in_byte == SYNC_FF) begin
                    phase_next = PH_AFTER_FF;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
        endcase
    end

    // header bytes never wait on the output side
    assign consume = ctl.in_vld && (!emits || ctl.out_rdy);
    assign res_vld = ctl.in_vld && emits;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT;
            remaining_reg <= '0;
            sum_reg       <= '0;
            length_reg    <= '0;
        end else if (consume) begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            sum_reg       <= sum_next;
            length_reg    <= length_next;
        end
    end
endmodule

/* design/sldf_out_reg.sv */
// Output register stage: holds one result item on the master side until it is taken.
module sldf_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  sldf_pkg::result_t res,
    output logic              out_rdy,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [7:0] out_byte, [15:8] frame_length
    output logic              m_tlast,   // is_last
    output logic              m_tuser    // checksum_ok
);
    import sldf_pkg::*;

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;

    assign out_rdy  = !vld_reg || m_tready;
    assign vld_next = load ? 1'b1 : (vld_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {res_reg.frame_length, res_reg.out_byte};
    assign m_tlast  = res_reg.is_last;
    assign m_tuser  = res_reg.checksum_ok;
endmodule

/* design/sync_length_checksum_deframer.sv */
// Top level of the sync/length/checksum deframer.
//
//   channel  dir  tdata                               tlast    tuser
//   s_       in   [7:0] rx_byte                       -        -
//   m_       out  [7:0] out_byte, [15:8] frame_length is_last  checksum_ok
//
// One item per cycle in both directions while m_tready does not stall. A result
// goes from the input register through the parser into the output register.
// Header, length and dropped bytes produce no result and never wait on m_tready.
// A stalled result item holds the parser; the input register then fills and
// s_tready drops. aresetn (synchronous) returns the parser to header hunt.
module sync_length_checksum_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [15:8] frame_length
    output logic        m_tlast,   // is_last
    output logic        m_tuser    // checksum_ok
);
    import sldf_pkg::*;

    logic              consume;
    logic              in_vld;
    logic [BYTE_W-1:0] in_byte;
    logic              out_rdy;
    logic              res_vld;
    result_t           res;
    stage_ctl_t        ctl;

    assign ctl.in_vld  = in_vld;
    assign ctl.out_rdy = out_rdy;

    sldf_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .consume  (consume),
        .in_vld   (in_vld),
        .in_byte  (in_byte)
    );

    sldf_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .in_byte  (in_byte),
        .consume  (consume),
        .res_vld  (res_vld),
        .res      (res)
    );

    sldf_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_vld && consume),
        .res      (res),
        .out_rdy  (out_rdy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );
endmodule

/* design/sldf_checker.sv */
// Port-level assertions for the deframer, bound to the top level.
module sldf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);
    // a stalled result item holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // checksum_ok is only ever set on the closing item
    a_ok_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !m_tuser)
        else $error("checksum_ok set on a payload item");

    // frames of zero length never produce items
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:8] != 8'd0)
        else $error("result item with zero frame length");

    // a new frame needs header and payload before its checksum item
    a_two_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !(m_tvalid && m_tlast))
        else $error("two checksum items back to back");

    // both registers come out of reset empty
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("pipeline not empty right after reset");
endmodule

bind sync_length_checksum_deframer sldf_checker u_sldf_checker (.*);

/* tb/tb_top.sv */
// Self-checking testbench for the sync/length/checksum deframer.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sldf_pkg::*;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_AFTER_FF,
        ST_LENGTH,
        ST_PAYLOAD,
        ST_CHECK
    } rx_phase_e;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;    // [7:0] out_byte, [15:8] frame_length
    logic        m_tlast;    // is_last
    logic        m_tuser;    // checksum_ok

    // expected output bytes, oldest first
    result_t   frame_bytes_due[$];

    // predictor state
    rx_phase_e rx_phase = ST_HUNT;
    logic [7:0] bytes_left = 8'h00;
    logic [7:0] sum_acc = 8'h00;
    logic [7:0] len_seen = 8'h00;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;
    int items_sent = 0;
    int framing_items = 0;
    int results_seen = 0;
    int frames_good = 0;
    int frames_bad = 0;
    int headers_dropped = 0;

    sync_length_checksum_deframer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Runs one received byte through the predictor. Returns 0 when the
    // block simply drops the byte while hunting or right after 0xFF.
    function automatic bit parse_rx_byte(input logic [7:0] b);
        result_t r;
        logic [8:0] diff;
        bit used;
        used = 1'b1;
        case (rx_phase)
            ST_AFTER_FF: begin
                if (b == SYNC_55) begin
                    rx_phase = ST_LENGTH;
                end else begin
                    rx_phase = ST_HUNT;
                    used = 1'b0;
                    headers_dropped++;
                end
            end
            ST_LENGTH: begin
                if (b == 8'h00) begin
                    rx_phase = ST_HUNT;
                    headers_dropped++;
                end else begin
                    len_seen = b;
                    bytes_left = b;
                    sum_acc = b;
                    rx_phase = ST_PAYLOAD;
                end
            end
            ST_PAYLOAD: begin
                r.out_byte = b;
                r.is_last = 1'b0;
                r.checksum_ok = 1'b0;
                r.frame_length = len_seen;
                frame_bytes_due.push_back(r);
                sum_acc = sum_acc + b;
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == 8'h00)
                    rx_phase = ST_CHECK;
            end
            ST_CHECK: begin
                diff = CHK_BASE - {1'b0, sum_acc};
                r.out_byte = b;
                r.is_last = 1'b1;
                r.checksum_ok = (b == diff[7:0]);
                r.frame_length = len_seen;
                frame_bytes_due.push_back(r);
                if (r.checksum_ok)
                    frames_good++;
                else
                    frames_bad++;
                rx_phase = ST_HUNT;
            end
            default: begin
                if (b == SYNC_55)
                    rx_phase = ST_LENGTH;
                else if (b == SYNC_FF)
                    rx_phase = ST_AFTER_FF;
                else begin
                    rx_phase = ST_HUNT;
                    used = 1'b0;
                end
            end
        endcase
        return used;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR at %0d ns: %s", $time, msg);
    endfunction

    // Called just after a rising edge; returns at the edge that accepts the item.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (parse_rx_byte(b))
            framing_items++;
    endtask

    task automatic send_frame(input bit with_ff, input logic [7:0] len, input bit spoil);
        logic [7:0] acc;
        logic [7:0] pb;
        logic [7:0] spoil_mask;
        logic [8:0] diff;
        if (with_ff)
            send_byte(SYNC_FF);
        send_byte(SYNC_55);
        send_byte(len);
        acc = len;
        for (int i = 0; i < len; i++) begin
            pb = 8'($urandom_range(255));
            send_byte(pb);
            acc = acc + pb;
        end
        diff = CHK_BASE - {1'b0, acc};
        spoil_mask = 8'($urandom_range(1, 255));
        send_byte(spoil ? (diff[7:0] ^ spoil_mask) : diff[7:0]);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Both header forms, payload and checksum at the byte extremes.
    task automatic test_header_forms();
        send_byte(SYNC_55);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_FF);
        send_byte(SYNC_55);
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'h00);
    endtask

    // Broken header, doubled 0xFF, stray bytes and a zero length.
    task automatic test_broken_header();
        send_byte(SYNC_FF);
        send_byte(8'h12);
        send_byte(SYNC_FF);
        send_byte(SYNC_FF);
        send_byte(8'h00);
        send_byte(8'hAA);
        send_byte(SYNC_55);
        send_byte(8'h00);
    endtask

    task automatic test_checksum_error();
        send_byte(SYNC_55);
        send_byte(8'h02);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'hFE);   // correct value would be 0xFF
    endtask

    task automatic test_max_length();
        send_frame(1'b1, 8'hFF, 1'b0);
    endtask

    // Mostly well-formed frames with random content, the rest broken or noise.
    task automatic test_random_frames(input int quota);
        int start;
        int pick;
        int n;
        logic [7:0] b;
        start = framing_items;
        while (framing_items - start < quota) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                send_frame(1'($urandom_range(1)), 8'(n), $urandom_range(3) == 0);
            end else if (pick < 85) begin
                b = 8'($urandom_range(255));
                send_byte(SYNC_FF);
                send_byte((b == SYNC_55) ? SYNC_FF : b);
            end else if (pick < 90) begin
                if ($urandom_range(1))
                    send_byte(SYNC_FF);
                send_byte(SYNC_55);
                send_byte(8'h00);
            end else begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        result_t seen;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen.out_byte = m_tdata[7:0];
            seen.frame_length = m_tdata[15:8];
            seen.is_last = m_tlast;
            seen.checksum_ok = m_tuser;
            results_seen++;
            if (frame_bytes_due.size() == 0) begin
                note_failure($sformatf("unexpected item: byte %h len %h last %b ok %b",
                    seen.out_byte, seen.frame_length, seen.is_last, seen.checksum_ok));
            end else begin
                want = frame_bytes_due.pop_front();
                if (seen.out_byte !== want.out_byte
                        || seen.frame_length !== want.frame_length
                        || seen.is_last !== want.is_last
                        || seen.checksum_ok !== want.checksum_ok)
                    note_failure($sformatf(
                        "byte %h/%h len %h/%h last %b/%b ok %b/%b (expected/actual)",
                        want.out_byte, seen.out_byte, want.frame_length,
                        seen.frame_length, want.is_last, seen.is_last,
                        want.checksum_ok, seen.checksum_ok));
            end
        end
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d items outstanding", frame_bytes_due.size());
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        set_idling(8, 69);
        test_header_forms();
        test_broken_header();
        test_checksum_error();
        test_random_frames(50);

        set_idling(69, 8);
        test_max_length();
        test_random_frames(50);

        set_idling(0, 0);
        test_random_frames(50);
        s_tvalid <= 1'b0;

        while (frame_bytes_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("sent %0d bytes (%0d in headers or frames), checked %0d output items",
            items_sent, framing_items, results_seen);
        $display("frames: %0d good checksum, %0d bad checksum, %0d headers dropped",
            frames_good, frames_bad, headers_dropped);
        if (fail_count == 0)
            $display("status: pass");
        else begin
            $display("%0d mismatches", fail_count);
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* files.f */
design/sldf_pkg.sv
design/sldf_in_reg.sv
design/sldf_parser.sv
design/sldf_out_reg.sv
design/sync_length_checksum_deframer.sv
design/sldf_checker.sv
tb/tb_top.sv
